FILE: sv/snt_pkg.sv
// Shared types, field positions and defaults for the sorting network tester.
`default_nettype none

package snt_pkg;

    localparam int LANES_DEF           = 8;
    localparam int VALUE_BITS_DEF      = 8;
    localparam int MAX_COMPARATORS_DEF = 32;
    localparam int COUNT_BITS_DEF      = 16;

    localparam int POS_BITS       = 3;
    localparam int SLOT_BITS      = 5;
    localparam int CFG_BITS       = 6;
    localparam int VECTOR_BITS    = 64;
    localparam int OUT_COUNT_BITS = 16;

    // Input tdata layout
    localparam int SLOT_LSB   = 0;
    localparam int POS_A_LSB  = SLOT_LSB + SLOT_BITS;
    localparam int POS_B_LSB  = POS_A_LSB + POS_BITS;
    localparam int VEC_LSB    = POS_B_LSB + POS_BITS;
    localparam int CLEAR_BIT  = VEC_LSB + VECTOR_BITS;
    localparam int IN_BITS    = CLEAR_BIT + 1;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout
    localparam int RES_LSB     = 0;
    localparam int PASS_LSB    = RES_LSB + VECTOR_BITS;
    localparam int FAIL_LSB    = PASS_LSB + OUT_COUNT_BITS;
    localparam int OUT_TDATA_W = FAIL_LSB + OUT_COUNT_BITS;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TEST  = 1'b1
    } snt_op_t;

    // Control part of a request moving down the cell chain
    typedef struct packed {
        logic                 valid;
        snt_op_t              op;
        logic                 clear;
        logic [SLOT_BITS-1:0] slot;
        logic [POS_BITS-1:0]  pos_a;
        logic [POS_BITS-1:0]  pos_b;
    } snt_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/snt_cell.sv
// One comparator cell: holds one network slot and one stage of the vector chain.
`default_nettype none

module snt_cell #(
    parameter int LANES      = snt_pkg::LANES_DEF,
    parameter int VALUE_BITS = snt_pkg::VALUE_BITS_DEF,
    parameter int INDEX      = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire logic [snt_pkg::CFG_BITS-1:0]     cfg_in_use,
    input  wire snt_pkg::snt_ctrl_t               ctrl_in,
    input  wire logic [LANES*VALUE_BITS-1:0]      vec_in,
    output snt_pkg::snt_ctrl_t                    ctrl_out,
    output logic [LANES*VALUE_BITS-1:0]           vec_out
);
    import snt_pkg::*;

    localparam int W = LANES * VALUE_BITS;

    logic [POS_BITS-1:0]   a_reg;
    logic [POS_BITS-1:0]   b_reg;
    logic                  valid_reg;
    snt_op_t               op_reg;
    logic                  clear_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [POS_BITS-1:0]   pos_a_reg;
    logic [POS_BITS-1:0]   pos_b_reg;
    logic [W-1:0]          vec_reg;

    logic [POS_BITS-1:0]   lo;
    logic [POS_BITS-1:0]   hi;
    logic [VALUE_BITS-1:0] v_lo;
    logic [VALUE_BITS-1:0] v_hi;
    logic                  do_swap;
    logic                  load_slot;
    logic [W-1:0]          vec_next;

    always_comb
    begin
        lo = (a_reg < b_reg) ? a_reg : b_reg;
        hi = (a_reg < b_reg) ? b_reg : a_reg;
        v_lo = '0;
        v_hi = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (int'(lo) == j)
                v_lo = vec_in[j*VALUE_BITS +: VALUE_BITS];
            if (int'(hi) == j)
                v_hi = vec_in[j*VALUE_BITS +: VALUE_BITS];
        end
        // skip pairs naming one lane twice or a lane beyond the vector
        do_swap = ctrl_in.valid && (ctrl_in.op == OP_TEST) && (INDEX < int'(cfg_in_use))
                  && (a_reg != b_reg) && (int'(a_reg) < LANES) && (int'(b_reg) < LANES)
                  && (v_lo > v_hi);
        vec_next = vec_in;
        if (do_swap)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                if (int'(lo) == j)
                    vec_next[j*VALUE_BITS +: VALUE_BITS] = v_hi;
                if (int'(hi) == j)
                    vec_next[j*VALUE_BITS +: VALUE_BITS] = v_lo;
            end
        end
        load_slot = advance && ctrl_in.valid && (ctrl_in.op == OP_WRITE)
                    && (int'(ctrl_in.slot) == INDEX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= ctrl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg    <= ctrl_in.op;
            clear_reg <= ctrl_in.clear;
            slot_reg  <= ctrl_in.slot;
            pos_a_reg <= ctrl_in.pos_a;
            pos_b_reg <= ctrl_in.pos_b;
            vec_reg   <= vec_next;
        end
        if (load_slot)
        begin
            a_reg <= ctrl_in.pos_a;
            b_reg <= ctrl_in.pos_b;
        end
    end

    assign ctrl_out = '{valid: valid_reg, op: op_reg, clear: clear_reg, slot: slot_reg,
                        pos_a: pos_a_reg, pos_b: pos_b_reg};
    assign vec_out  = vec_reg;

endmodule

`default_nettype wire

FILE: sv/snt_tally.sv
// End of the chain: order check, saturating pass/fail counts and output register.
`default_nettype none

module snt_tally #(
    parameter int LANES      = snt_pkg::LANES_DEF,
    parameter int VALUE_BITS = snt_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = snt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 advance,
    input  wire snt_pkg::snt_ctrl_t                   ctrl_in,
    input  wire logic [LANES*VALUE_BITS-1:0]          vec_in,
    output logic                                      out_valid,
    output logic                                      vector_sorted,
    output logic [snt_pkg::VECTOR_BITS-1:0]           result_vector,
    output logic [snt_pkg::OUT_COUNT_BITS-1:0]        sorted_total,
    output logic [snt_pkg::OUT_COUNT_BITS-1:0]        unsorted_total
);
    import snt_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                   out_valid_reg;
    logic                   sorted_reg;
    logic [VECTOR_BITS-1:0] result_reg;
    logic [COUNT_BITS-1:0]  pass_reg;
    logic [COUNT_BITS-1:0]  fail_reg;
    logic [COUNT_BITS-1:0]  pass_next;
    logic [COUNT_BITS-1:0]  fail_next;
    logic [COUNT_BITS-1:0]  pass_base;
    logic [COUNT_BITS-1:0]  fail_base;
    logic                   sorted;
    logic                   is_test;

    always_comb
    begin
        sorted = 1'b1;
        for (int j = 1; j < LANES; j++)
        begin
            if (vec_in[(j-1)*VALUE_BITS +: VALUE_BITS] > vec_in[j*VALUE_BITS +: VALUE_BITS])
                sorted = 1'b0;
        end
        is_test   = ctrl_in.valid && (ctrl_in.op == OP_TEST);
        pass_base = ctrl_in.clear ? '0 : pass_reg;
        fail_base = ctrl_in.clear ? '0 : fail_reg;
        pass_next = pass_base;
        fail_next = fail_base;
        if (sorted)
        begin
            if (pass_base != COUNT_MAX)
                pass_next = pass_base + 1'b1;
        end
        else if (fail_base != COUNT_MAX)
            fail_next = fail_base + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pass_reg      <= '0;
            fail_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= is_test;
            if (is_test)
            begin
                pass_reg <= pass_next;
                fail_reg <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_test)
        begin
            sorted_reg <= sorted;
            result_reg <= VECTOR_BITS'(vec_in);
        end
    end

    assign out_valid      = out_valid_reg;
    assign vector_sorted  = sorted_reg;
    assign result_vector  = result_reg;
    assign sorted_total   = OUT_COUNT_BITS'(pass_reg);
    assign unsorted_total = OUT_COUNT_BITS'(fail_reg);

endmodule

`default_nettype wire

FILE: sv/sorting_network_tester.sv
// Top level: comparator network tester built as a chain of comparator cells.
// Throughput: one request per cycle unless stalled; each cell applies one comparator and passes the vector on.
// A test request is registered in each cell in turn, then its result is registered in the output register.
// Slot writes travel down the same chain, so they take effect in request order; they give no result.
// The whole chain holds while a result waits on the output side.
// Reset clears the counts, comparators_in_use and all valid bits; comparator slots are undefined until written.
`default_nettype none

module sorting_network_tester #(
    parameter int LANES           = snt_pkg::LANES_DEF,
    parameter int VALUE_BITS      = snt_pkg::VALUE_BITS_DEF,
    parameter int MAX_COMPARATORS = snt_pkg::MAX_COMPARATORS_DEF,
    parameter int COUNT_BITS      = snt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [snt_pkg::CFG_BITS-1:0]      cfg_data,      // comparators_in_use
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // slot[4:0], pos_a[7:5], pos_b[10:8], test_vector[74:11], clear_counts[75], zero pad
    input  wire logic [snt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tuser,  // opcode
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // result_vector[63:0], sorted_total[79:64], unsorted_total[95:80]
    output logic [snt_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tuser   // vector_sorted
);
    import snt_pkg::*;

    localparam int W = LANES * VALUE_BITS;

    logic [CFG_BITS-1:0]     cfg_in_use_reg;
    logic                    advance;
    logic                    out_valid;
    logic                    vector_sorted;
    logic [VECTOR_BITS-1:0]  result_vector;
    logic [OUT_COUNT_BITS-1:0] sorted_total;
    logic [OUT_COUNT_BITS-1:0] unsorted_total;

    snt_ctrl_t               ctrl_chain [0:MAX_COMPARATORS];
    logic [W-1:0]            vec_chain  [0:MAX_COMPARATORS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_in_use_reg <= '0;
        else if (cfg_we)
            cfg_in_use_reg <= cfg_data;
    end

    assign advance       = !out_valid || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        ctrl_chain[0].valid = s_axis_tvalid;
        ctrl_chain[0].op    = snt_op_t'(s_axis_tuser);
        ctrl_chain[0].clear = s_axis_tdata[CLEAR_BIT];
        ctrl_chain[0].slot  = s_axis_tdata[SLOT_LSB +: SLOT_BITS];
        ctrl_chain[0].pos_a = s_axis_tdata[POS_A_LSB +: POS_BITS];
        ctrl_chain[0].pos_b = s_axis_tdata[POS_B_LSB +: POS_BITS];
        // lanes past the input word read as zero, input bits past the lanes drop
        vec_chain[0]        = W'(s_axis_tdata[VEC_LSB +: VECTOR_BITS]);
    end

    for (genvar i = 0; i < MAX_COMPARATORS; i++)
    begin : g_cell
        snt_cell #(
            .LANES      (LANES),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cfg_in_use (cfg_in_use_reg),
            .ctrl_in    (ctrl_chain[i]),
            .vec_in     (vec_chain[i]),
            .ctrl_out   (ctrl_chain[i+1]),
            .vec_out    (vec_chain[i+1])
        );
    end

    snt_tally #(
        .LANES      (LANES),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .ctrl_in        (ctrl_chain[MAX_COMPARATORS]),
        .vec_in         (vec_chain[MAX_COMPARATORS]),
        .out_valid      (out_valid),
        .vector_sorted  (vector_sorted),
        .result_vector  (result_vector),
        .sorted_total   (sorted_total),
        .unsorted_total (unsorted_total)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = vector_sorted;
    assign m_axis_tdata  = {unsorted_total, sorted_total, result_vector};

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the sorting network tester: directed table and random phases.
`timescale 1ns / 100ps

module tb_top;
    import snt_pkg::*;

    localparam int LANES      = LANES_DEF;
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int MAX_CMP    = MAX_COMPARATORS_DEF;
    localparam int DIR_ROWS   = 19;

    typedef struct packed {
        logic                      sorted;
        logic [VECTOR_BITS-1:0]    vec;
        logic [OUT_COUNT_BITS-1:0] pass_cnt;
        logic [OUT_COUNT_BITS-1:0] fail_cnt;
    } net_result_t;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        snt_op_t                op;
        logic [SLOT_BITS-1:0]   slot;
        logic [POS_BITS-1:0]    pos_a;
        logic [POS_BITS-1:0]    pos_b;
        logic [VECTOR_BITS-1:0] vec;
        logic                   clr;
        logic [CFG_BITS-1:0]    cfg;
        logic                   chk;
        net_result_t            want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_BITS-1:0]    cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // predictor state
    logic [POS_BITS-1:0]       net_pos_a [MAX_CMP];
    logic [POS_BITS-1:0]       net_pos_b [MAX_CMP];
    logic [CFG_BITS-1:0]       in_use_cfg = '0;
    logic [OUT_COUNT_BITS-1:0] pass_cnt = '0;
    logic [OUT_COUNT_BITS-1:0] fail_cnt = '0;

    net_result_t pending_results [$];
    int          mismatches = 0;
    bit          gappy = 1'b1;

    // expected field is typed in only where it is obvious
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0, 1'b0, 6'd0, 1'b1,
          '{1'b1, 64'h0, 16'd1, 16'd0}},
        '{ROW_REQ, OP_TEST, 5'd31, 3'd7, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0, 1'b1,
          '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 16'd0}},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0001_0203_0405_0607, 1'b0, 6'd0, 1'b1,
          '{1'b0, 64'h0001_0203_0405_0607, 16'd2, 16'd1}},
        // clear happens before this test is counted
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0001_0203_0405_0607, 1'b1, 6'd0, 1'b1,
          '{1'b0, 64'h0001_0203_0405_0607, 16'd0, 16'd1}},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0706_0504_0302_0100, 1'b0, 6'd0, 1'b1,
          '{1'b1, 64'h0706_0504_0302_0100, 16'd1, 16'd1}},
        '{ROW_REQ, OP_WRITE, 5'd0, 3'd0, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_WRITE, 5'd1, 3'd2, 3'd2, 64'h0, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_WRITE, 5'd2, 3'd7, 3'd6, 64'h0, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_WRITE, 5'd3, 3'd0, 3'd7, 64'h0, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd5, 3'd3, 3'd4, 64'h0706_0504_0302_0100, 1'b0, 6'd0, 1'b1,
          '{1'b1, 64'h0706_0504_0302_0100, 16'd2, 16'd1}},
        '{ROW_CFG, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0, 1'b0, 6'd4, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0001_0203_0405_0607, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0000_0000_0000_00FF, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'hFF00_0000_0000_0000, 1'b1, 6'd0, 1'b0, '0},
        '{ROW_CFG, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0, 1'b0, 6'd1, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0000_0000_0000_00FF, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h1234_5678_9ABC_DEF0, 1'b0, 6'd0, 1'b0, '0},
        '{ROW_REQ, OP_TEST, 5'd0, 3'd0, 3'd0, 64'h0, 1'b1, 6'd0, 1'b0, '0}
    };

    sorting_network_tester u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_req(input logic [SLOT_BITS-1:0] slot,
                                                      input logic [POS_BITS-1:0] pa,
                                                      input logic [POS_BITS-1:0] pb,
                                                      input logic [VECTOR_BITS-1:0] vec,
                                                      input logic clr);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[SLOT_LSB +: SLOT_BITS]    = slot;
        d[POS_A_LSB +: POS_BITS]    = pa;
        d[POS_B_LSB +: POS_BITS]    = pb;
        d[VEC_LSB +: VECTOR_BITS]   = vec;
        d[CLEAR_BIT]                = clr;
        return d;
    endfunction

    // mix of fully random, few-valued, flat and ascending vectors
    function automatic logic [VECTOR_BITS-1:0] rand_vector();
        logic [VECTOR_BITS-1:0] v;
        int kind;
        kind = $urandom_range(0, 99);
        v = {$urandom(), $urandom()};
        if (kind >= 45)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (kind < 70)
                begin
                    case ($urandom_range(0, 2))
                        0:       v[i*VALUE_BITS +: VALUE_BITS] = 8'h00;
                        1:       v[i*VALUE_BITS +: VALUE_BITS] = 8'h80;
                        default: v[i*VALUE_BITS +: VALUE_BITS] = 8'hFF;
                    endcase
                end
                else if (kind < 85)
                    v[i*VALUE_BITS +: VALUE_BITS] = v[VALUE_BITS-1:0];
                else
                    v[i*VALUE_BITS +: VALUE_BITS] = 8'(i * 32 + $urandom_range(0, 31));
            end
        end
        return v;
    endfunction

    // applies one request to the predictor; a test yields one expected result
    task automatic run_network(input snt_op_t op, input logic [IN_TDATA_W-1:0] data,
                               output logic made, output net_result_t res);
        logic [VALUE_BITS-1:0]  lane_v [LANES];
        logic [VALUE_BITS-1:0]  tmp;
        logic [SLOT_BITS-1:0]   slot;
        logic [POS_BITS-1:0]    a;
        logic [POS_BITS-1:0]    b;
        logic [POS_BITS-1:0]    lo;
        logic [POS_BITS-1:0]    hi;
        logic [VECTOR_BITS-1:0] vec;
        int                     n;
        made = 1'b0;
        res  = '0;
        slot = data[SLOT_LSB +: SLOT_BITS];
        a    = data[POS_A_LSB +: POS_BITS];
        b    = data[POS_B_LSB +: POS_BITS];
        vec  = data[VEC_LSB +: VECTOR_BITS];
        if (op == OP_WRITE)
        begin
            net_pos_a[slot] = a;
            net_pos_b[slot] = b;
            return;
        end
        for (int i = 0; i < LANES; i++)
            lane_v[i] = vec[i*VALUE_BITS +: VALUE_BITS];
        n = (int'(in_use_cfg) > MAX_CMP) ? MAX_CMP : int'(in_use_cfg);
        for (int i = 0; i < n; i++)
        begin
            a = net_pos_a[i];
            b = net_pos_b[i];
            if (a != b)
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                if (lane_v[lo] > lane_v[hi])
                begin
                    tmp        = lane_v[lo];
                    lane_v[lo] = lane_v[hi];
                    lane_v[hi] = tmp;
                end
            end
        end
        res.sorted = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            res.vec[i*VALUE_BITS +: VALUE_BITS] = lane_v[i];
            if (i > 0 && lane_v[i-1] > lane_v[i])
                res.sorted = 1'b0;
        end
        if (data[CLEAR_BIT])
        begin
            pass_cnt = '0;
            fail_cnt = '0;
        end
        if (res.sorted)
        begin
            if (pass_cnt != '1)
                pass_cnt = pass_cnt + 1'b1;
        end
        else if (fail_cnt != '1)
            fail_cnt = fail_cnt + 1'b1;
        res.pass_cnt = pass_cnt;
        res.fail_cnt = fail_cnt;
        made = 1'b1;
    endtask

    // called and returns at a falling edge
    task automatic put_req(input snt_op_t op, input logic [IN_TDATA_W-1:0] data,
                           input logic chk, input net_result_t want);
        int          gap;
        logic        made;
        net_result_t res;
        gap = gappy ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        run_network(op, data, made, res);
        if (made)
            pending_results.push_back(chk ? want : res);
        @(negedge clk);
    endtask

    // writes give no result, so wait out the chain after the last expected result
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MAX_CMP + 8) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_BITS-1:0] value);
        drain_pipe();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        in_use_cfg = value;
    endtask

    // fills all slots; optionally slots 0..27 hold an odd-even transposition sorter
    task automatic load_network(input bit sorter);
        int s;
        s = 0;
        if (sorter)
        begin
            for (int r = 0; r < LANES; r++)
            begin
                for (int p = r % 2; p + 1 < LANES; p += 2)
                begin
                    put_req(OP_WRITE, pack_req(5'(s), 3'(p + 1), 3'(p), rand_vector(),
                                               1'($urandom_range(0, 1))), 1'b0, '0);
                    s++;
                end
            end
        end
        while (s < MAX_CMP)
        begin
            put_req(OP_WRITE, pack_req(5'(s), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                       rand_vector(), 1'b0), 1'b0, '0);
            s++;
        end
    endtask

    task automatic random_phase(input int count, input int first_free);
        bit                   is_wr;
        logic [SLOT_BITS-1:0] slot;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 199) == 0)
                drain_pipe();
            is_wr = ($urandom_range(0, 99) < 15);
            slot  = is_wr ? 5'($urandom_range(first_free, MAX_CMP - 1)) : 5'($urandom());
            put_req(is_wr ? OP_WRITE : OP_TEST,
                    pack_req(slot, 3'($urandom()), 3'($urandom()), rand_vector(),
                             $urandom_range(0, 99) < 3), 1'b0, '0);
        end
    endtask

    // result side back-pressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!gappy)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        net_result_t want;
        net_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.sorted   = m_axis_tuser;
            got.vec      = m_axis_tdata[RES_LSB +: VECTOR_BITS];
            got.pass_cnt = m_axis_tdata[PASS_LSB +: OUT_COUNT_BITS];
            got.fail_cnt = m_axis_tdata[FAIL_LSB +: OUT_COUNT_BITS];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sorted %b vec %h pass %0d fail %0d",
                             got.sorted, got.vec, got.pass_cnt, got.fail_cnt);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.sorted !== want.sorted || got.vec !== want.vec ||
                    got.pass_cnt !== want.pass_cnt || got.fail_cnt !== want.fail_cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %b %h %0d %0d, got %b %h %0d %0d",
                                 want.sorted, want.vec, want.pass_cnt, want.fail_cnt,
                                 got.sorted, got.vec, got.pass_cnt, got.fail_cnt);
                end
            end
        end
    end

    initial
    begin
        #(64'd3_000_000 * 12);
        $display("sorting_network_tester regression: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_cfg(dir_rows[i].cfg);
            else
                put_req(dir_rows[i].op,
                        pack_req(dir_rows[i].slot, dir_rows[i].pos_a, dir_rows[i].pos_b,
                                 dir_rows[i].vec, dir_rows[i].clr),
                        dir_rows[i].chk, dir_rows[i].want);
        end

        load_network(1'b0);
        write_cfg(6'd32);
        random_phase(220, 0);

        // full sorter, no idling on either side; writes kept off the sorter slots
        load_network(1'b1);
        gappy = 1'b0;
        write_cfg(6'd28);
        random_phase(220, 28);
        gappy = 1'b1;

        write_cfg(6'd63);
        random_phase(200, 0);
        write_cfg(6'd33);
        random_phase(150, 0);
        write_cfg(6'd0);
        random_phase(150, 0);
        write_cfg(6'd1);
        random_phase(150, 0);
        write_cfg(6'($urandom_range(2, 31)));
        random_phase(280, 0);

        put_req(OP_TEST, pack_req(5'd0, 3'd0, 3'd0, rand_vector(), 1'b1), 1'b0, '0);

        drain_pipe();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("sorting_network_tester regression: pass");
        else
            $display("sorting_network_tester regression: fail");
        $finish;
    end

endmodule
